// ----- rtl/strided_sync_correlator_macros.svh -----
// Assertion macros shared by the strided sync correlator RTL.
`ifndef STRIDED_SYNC_CORRELATOR_MACROS_SVH
`define STRIDED_SYNC_CORRELATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SSC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SSC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ssc_pkg.sv -----
// Package: shared constants, state type and symbol product for the correlator.
`default_nettype none

package ssc_pkg;

  localparam int SAMPLES_PER_SYM = 10;
  localparam int SYNC_LEN        = 8;

  localparam int SAMPLE_W = 16;
  localparam int SYNC_W   = 16;
  localparam int PHASE_W  = 4;
  localparam int CORR_W   = 21;
  localparam int HIGH_W   = 15;
  localparam int PROD_W   = SAMPLE_W + 2;

  localparam logic [1:0] SYM_P1 = 2'd0;
  localparam logic [1:0] SYM_P3 = 2'd1;
  localparam logic [1:0] SYM_N1 = 2'd2;
  localparam logic [1:0] SYM_N3 = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_SCAN,
    S_DIV_START,
    S_DIV_WAIT,
    S_DONE
  } state_t;

  function automatic logic signed [PROD_W-1:0] sym_product(
    input logic [1:0]                 code,
    input logic signed [SAMPLE_W-1:0] smp
  );
    logic signed [PROD_W-1:0] s;
    logic signed [PROD_W-1:0] t;
    logic signed [PROD_W-1:0] r;
    s = PROD_W'(smp);
    t = s + (s <<< 1);
    unique case (code)
      SYM_P1: r = s;
      SYM_P3: r = t;
      SYM_N1: r = -s;
      SYM_N3: r = -t;
      default: r = s;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ssc_cell.sv -----
// Ring cell: one stored sample, loaded from its neighbor on shift.
`default_nettype none

module ssc_cell (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  shift_en,
  input  wire logic signed [ssc_pkg::SAMPLE_W-1:0]   d_in,
  output logic signed [ssc_pkg::SAMPLE_W-1:0]        d_out
);

  logic signed [ssc_pkg::SAMPLE_W-1:0] smp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_r <= '0;
    end else if (shift_en) begin
      smp_r <= d_in;
    end
  end

  assign d_out = smp_r;

endmodule

`default_nettype wire

// ----- rtl/ssc_div.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module ssc_div #(
  parameter int DVD_W = 20,
  parameter int DVS_W = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0]      quotient,
  output logic                  done
);

  localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;

  logic [DVS_W:0]   rem_sh;
  logic             fits;
  logic [DVS_W:0]   rem_sub;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DVD_W-1]};
    fits    = rem_sh >= {1'b0, dvs_r};
    rem_sub = rem_sh - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], fits};
      rem_r <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

`default_nettype wire

// ----- rtl/strided_sync_correlator.sv -----
// Top level: strided sync-word correlator with outer level estimation.
//
//   channel | direction | signals                               | handshake
//   in      | input     | in_kind, in_sample, in_phase          | in_valid / in_ready
//   out     | output    | out_is_levels .. out_high_valid       | out_valid / out_ready
//   cfg     | input     | cfg_wr_data                           | cfg_wr_en, no wait
//
// One request at a time. Sample request: shift, product stage, one accumulate
// per sync symbol through the product chain, result. Level request: the ring
// rotates once past its last cell, then two serial dividers take one bit per
// cycle. Reset clears the ring cells, write position and sync word. A stalled
// output holds the finished result; the next request is taken once the result
// is in the output register.
`default_nettype none

module strided_sync_correlator #(
  parameter int SAMPLES_PER_SYM = ssc_pkg::SAMPLES_PER_SYM,
  parameter int SYNC_LEN        = ssc_pkg::SYNC_LEN
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_wr_en,
  input  wire logic [ssc_pkg::SYNC_W-1:0]             cfg_wr_data,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic                                   in_kind,
  input  wire logic signed [ssc_pkg::SAMPLE_W-1:0]    in_sample,
  input  wire logic [ssc_pkg::PHASE_W-1:0]            in_phase,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic                                        out_is_levels,
  output logic signed [ssc_pkg::CORR_W-1:0]           out_correlation,
  output logic signed [ssc_pkg::SAMPLE_W-1:0]         out_low_level,
  output logic [ssc_pkg::HIGH_W-1:0]                  out_high_level,
  output logic                                        out_low_valid,
  output logic                                        out_high_valid
);

  `include "strided_sync_correlator_macros.svh"

  localparam int SAMPLE_W    = ssc_pkg::SAMPLE_W;
  localparam int PHASE_W     = ssc_pkg::PHASE_W;
  localparam int PROD_W      = ssc_pkg::PROD_W;
  localparam int CORR_W      = ssc_pkg::CORR_W;
  localparam int RING_N      = SAMPLES_PER_SYM * SYNC_LEN;
  localparam int POS_W       = $clog2(RING_N);
  localparam int SUB_W       = $clog2(SAMPLES_PER_SYM);
  localparam int SC_W        = $clog2(SYNC_LEN);
  localparam int CNT_W       = $clog2(SYNC_LEN + 1);
  localparam int SUM_W       = SAMPLE_W + CNT_W;
  localparam int ACC_W       = PROD_W + SC_W + 2;
  localparam int EXT_W       = SAMPLE_W + 1;
  localparam int CMP_W       = (POS_W > PHASE_W) ? POS_W : PHASE_W;
  localparam int PHASE_STEPS = ((1 << PHASE_W) - 1) / SAMPLES_PER_SYM;
  localparam int SYNC_EXT_W  = 2 * SYNC_LEN + ssc_pkg::SYNC_W;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (CORR_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(1 << (CORR_W - 1)));

  ssc_pkg::state_t state_r, state_nxt;

  logic [ssc_pkg::SYNC_W-1:0] sync_word_r;
  logic [POS_W-1:0]           wp_r;
  logic [SUB_W-1:0]           wp_sub_r;

  logic [PHASE_W-1:0]         phase_r;
  logic [SUB_W-1:0]           phase_res_r;
  logic [PHASE_W:0]           phase_rem;

  logic [POS_W-1:0]           pos_r;
  logic [SUB_W-1:0]           pos_sub_r;
  logic [POS_W-1:0]           step_r;

  logic signed [PROD_W-1:0]   prod_r [SYNC_LEN];
  logic [SC_W-1:0]            sum_cnt_r;
  logic signed [ACC_W-1:0]    acc_r;

  logic [SUM_W-1:0]           pos_sum_r;
  logic [SUM_W-1:0]           neg_mag_r;
  logic [CNT_W-1:0]           pos_cnt_r;
  logic [CNT_W-1:0]           neg_cnt_r;

  logic                       out_valid_r;
  logic                       out_is_levels_r;
  logic signed [CORR_W-1:0]   out_corr_r;
  logic signed [SAMPLE_W-1:0] out_low_r;
  logic [ssc_pkg::HIGH_W-1:0] out_high_r;
  logic                       out_low_valid_r;
  logic                       out_high_valid_r;

  logic                       kind_r;
  logic                       accept;
  logic                       accept_smp;
  logic                       accept_lvl;
  logic                       ring_shift;
  logic signed [SAMPLE_W-1:0] ring_in;
  logic signed [SAMPLE_W-1:0] cell_q [RING_N];
  logic signed [SAMPLE_W-1:0] tap;
  logic signed [EXT_W-1:0]    tap_ext;
  logic signed [EXT_W-1:0]    tap_neg;
  logic                       hit;
  logic                       div_start;
  logic                       div_done_p;
  logic                       div_done_n;
  logic [SUM_W-1:0]           quo_p;
  logic [SUM_W-1:0]           quo_n;
  logic                       load_out;
  logic [SYNC_EXT_W-1:0]      sync_ext;

  assign accept     = in_valid && in_ready;
  assign accept_smp = accept && !in_kind;
  assign accept_lvl = accept && in_kind;
  assign ring_shift = accept_smp || (state_r == ssc_pkg::S_SCAN);
  assign ring_in    = accept_smp ? in_sample : cell_q[RING_N-1];
  assign sync_ext   = {{(2 * SYNC_LEN){1'b0}}, sync_word_r};

  // Sample ring: cell 0 holds the newest sample.
  for (genvar k = 0; k < RING_N; k++) begin : g_ring
    if (k == 0) begin : g_head
      ssc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (ring_shift),
        .d_in     (ring_in),
        .d_out    (cell_q[k])
      );
    end else begin : g_body
      ssc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (ring_shift),
        .d_in     (cell_q[k-1]),
        .d_out    (cell_q[k])
      );
    end
  end

  // Phase reduced modulo samples per symbol.
  always_comb begin
    phase_rem = {1'b0, in_phase};
    for (int i = 0; i < PHASE_STEPS; i++) begin
      if (phase_rem >= (PHASE_W + 1)'(SAMPLES_PER_SYM)) begin
        phase_rem = phase_rem - (PHASE_W + 1)'(SAMPLES_PER_SYM);
      end
    end
  end

  // Scan tap at the ring end; pos_r is its ring position.
  always_comb begin
    tap     = cell_q[RING_N-1];
    tap_ext = EXT_W'(tap);
    tap_neg = -tap_ext;
    hit     = (CMP_W'(pos_r) >= CMP_W'(phase_r)) && (pos_sub_r == phase_res_r);
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ssc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = in_kind ? ssc_pkg::S_SCAN : ssc_pkg::S_MUL;
        end
      end
      ssc_pkg::S_MUL: begin
        state_nxt = ssc_pkg::S_SUM;
      end
      ssc_pkg::S_SUM: begin
        if (sum_cnt_r == SC_W'(SYNC_LEN - 1)) begin
          state_nxt = ssc_pkg::S_DONE;
        end
      end
      ssc_pkg::S_SCAN: begin
        if (step_r == POS_W'(RING_N - 1)) begin
          state_nxt = ssc_pkg::S_DIV_START;
        end
      end
      ssc_pkg::S_DIV_START: begin
        div_start = 1'b1;
        state_nxt = ssc_pkg::S_DIV_WAIT;
      end
      ssc_pkg::S_DIV_WAIT: begin
        if (div_done_p) begin
          state_nxt = ssc_pkg::S_DONE;
        end
      end
      ssc_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ssc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ssc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r <= '0;
    end else if (cfg_wr_en) begin
      sync_word_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      wp_sub_r <= '0;
    end else if (accept_smp) begin
      wp_r     <= (wp_r == POS_W'(RING_N - 1)) ? '0 : wp_r + 1'b1;
      wp_sub_r <= (wp_sub_r == SUB_W'(SAMPLES_PER_SYM - 1)) ? '0 : wp_sub_r + 1'b1;
    end
  end

  // Correlation: products at the symbol taps, then accumulated down the chain.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
    end
    if (state_r == ssc_pkg::S_MUL) begin
      for (int i = 0; i < SYNC_LEN; i++) begin
        prod_r[i] <= ssc_pkg::sym_product(sync_ext[2 * (SYNC_LEN - 1 - i) +: 2],
                                          cell_q[(SYNC_LEN - 1 - i) * SAMPLES_PER_SYM]);
      end
      acc_r     <= '0;
      sum_cnt_r <= '0;
    end else if (state_r == ssc_pkg::S_SUM) begin
      acc_r     <= acc_r + ACC_W'(prod_r[0]);
      sum_cnt_r <= sum_cnt_r + 1'b1;
      for (int i = 0; i < SYNC_LEN - 1; i++) begin
        prod_r[i] <= prod_r[i+1];
      end
    end
  end

  // Level scan over one full ring rotation.
  always_ff @(posedge clk) begin
    if (accept_lvl) begin
      phase_r     <= in_phase;
      phase_res_r <= SUB_W'(phase_rem);
      pos_r       <= wp_r;
      pos_sub_r   <= wp_sub_r;
      step_r      <= '0;
      pos_sum_r   <= '0;
      neg_mag_r   <= '0;
      pos_cnt_r   <= '0;
      neg_cnt_r   <= '0;
    end else if (state_r == ssc_pkg::S_SCAN) begin
      pos_r     <= (pos_r == POS_W'(RING_N - 1)) ? '0 : pos_r + 1'b1;
      pos_sub_r <= (pos_sub_r == SUB_W'(SAMPLES_PER_SYM - 1)) ? '0 : pos_sub_r + 1'b1;
      step_r    <= step_r + 1'b1;
      if (hit && (tap > 0)) begin
        pos_sum_r <= pos_sum_r + SUM_W'(unsigned'(tap_ext));
        pos_cnt_r <= pos_cnt_r + 1'b1;
      end else if (hit && (tap < 0)) begin
        neg_mag_r <= neg_mag_r + SUM_W'(unsigned'(tap_neg));
        neg_cnt_r <= neg_cnt_r + 1'b1;
      end
    end
  end

  ssc_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div_pos (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (pos_sum_r),
    .divisor  (pos_cnt_r),
    .quotient (quo_p),
    .done     (div_done_p)
  );

  ssc_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div_neg (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (neg_mag_r),
    .divisor  (neg_cnt_r),
    .quotient (quo_n),
    .done     (div_done_n)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_is_levels_r <= kind_r;
      if (kind_r) begin
        out_corr_r       <= '0;
        out_low_valid_r  <= neg_cnt_r != '0;
        out_high_valid_r <= pos_cnt_r != '0;
        out_low_r        <= (neg_cnt_r != '0) ? -signed'(quo_n[SAMPLE_W-1:0]) : '0;
        out_high_r       <= (pos_cnt_r != '0) ? quo_p[ssc_pkg::HIGH_W-1:0] : '0;
      end else begin
        if (acc_r > SAT_HI) begin
          out_corr_r <= SAT_HI[CORR_W-1:0];
        end else if (acc_r < SAT_LO) begin
          out_corr_r <= SAT_LO[CORR_W-1:0];
        end else begin
          out_corr_r <= acc_r[CORR_W-1:0];
        end
        out_low_valid_r  <= 1'b0;
        out_high_valid_r <= 1'b0;
        out_low_r        <= '0;
        out_high_r       <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_levels   = out_is_levels_r;
  assign out_correlation = out_corr_r;
  assign out_low_level   = out_low_r;
  assign out_high_level  = out_high_r;
  assign out_low_valid   = out_low_valid_r;
  assign out_high_valid  = out_high_valid_r;

  `SSC_ASSERT_NXT(a_accept_busy, accept, state_r != ssc_pkg::S_IDLE, "request taken but fsm idle")
  `SSC_ASSERT_IMP(a_div_sync, div_done_p || div_done_n, div_done_p && div_done_n && state_r == ssc_pkg::S_DIV_WAIT, "divider done out of step")
  `SSC_ASSERT_NXT(a_done_loads, load_out, out_valid_r && state_r == ssc_pkg::S_IDLE, "result not loaded")
  `SSC_ASSERT_IMP(a_wp_sub, wp_r == '0, wp_sub_r == '0, "write position phase mismatch")

endmodule

`default_nettype wire
